// ===== rtl/core/csc_pkg.sv =====
package csc_pkg;

    localparam int ANGLE_W        = 16;
    localparam int OUT_W          = 16;
    localparam int TABLE_LEN      = 16;
    localparam int ITERATIONS_DEF = 7;
    localparam int FRAC_BITS_DEF  = 14;

    // Rotation gain 0.6073 in Q30
    localparam logic signed [31:0] GAIN_Q30 = 32'sd652083410;
    localparam int GAIN_SHIFT = 30;

    localparam int OUT_MAX = 32767;
    localparam int OUT_MIN = -32768;

    // atan(2^-i) in Q30, rounded to nearest
    localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768
    };

    // atan(2^-idx) rounded half up to frac fraction bits
    function automatic logic [31:0] csc_atan(input int unsigned idx, input int unsigned frac);
        logic [32:0] v;
        int unsigned drop;
        v    = {1'b0, ATAN_Q30[idx[3:0]]};
        drop = (frac >= 30) ? 0 : 30 - frac;
        if (drop != 0) begin
            v = v + (33'd1 << (drop - 1));
            v = v >> drop;
        end
        return v[31:0];
    endfunction

endpackage

// ===== rtl/core/cordic_sin_cos.sv =====
// Channel  | Handshake                 | Payload
// ---------+---------------------------+----------------------------------
// input    | i_in_valid / o_in_ready   | i_angle   signed Q2.14 radians
// output   | o_out_valid / i_out_ready | o_sine, o_cosine  signed Q2.14
//
// The pipeline holds one register stage per micro-rotation, one for the gain
// multiply and one for the saturated output register. Throughput is one
// transaction per cycle while the output side accepts: every micro-rotation
// is unrolled into its own stage, so no hardware is reused across cycles.
// Each stage loads when it is empty or when the stage after it loads, so a
// stalled output holds its result while earlier bubbles still fill up.
// Reset (i_rst_n low, synchronous) clears all stage valid bits only.
module cordic_sin_cos
    import csc_pkg::*;
#(
    parameter int ITERATIONS = ITERATIONS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [ANGLE_W-1:0] i_angle,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [OUT_W-1:0]   o_sine,
    output logic signed [OUT_W-1:0]   o_cosine
);

    // x and y stay below 1.65 in magnitude; z holds the input plus all atans
    localparam int XW = FRAC_BITS + 3;
    localparam int ZW = (FRAC_BITS + 3 > 17) ? FRAC_BITS + 3 : 17;
    localparam int PW = XW + 32;
    // rotation stages, then multiply, then output
    localparam int S  = ITERATIONS + 2;

    localparam logic signed [XW-1:0] X_INIT = XW'(64'd1 << FRAC_BITS);
    localparam logic signed [PW-1:0] SAT_HI = PW'(OUT_MAX);
    localparam logic signed [PW-1:0] SAT_LO = PW'(OUT_MIN);

    logic [S-1:0] r_vld;
    logic [S-1:0] n_vld;
    logic [S-1:0] w_ld;
    logic [S-1:0] w_vld_in;

    logic signed [XW-1:0] w_x [ITERATIONS+1];
    logic signed [XW-1:0] w_y [ITERATIONS+1];
    logic signed [ZW-1:0] w_z [ITERATIONS+1];

    logic signed [PW-1:0] r_prod_s;
    logic signed [PW-1:0] r_prod_c;
    logic signed [PW-1:0] w_sh_s;
    logic signed [PW-1:0] w_sh_c;
    logic signed [OUT_W-1:0] n_sine;
    logic signed [OUT_W-1:0] n_cosine;
    logic signed [OUT_W-1:0] r_sine;
    logic signed [OUT_W-1:0] r_cosine;

    // Load chain: a stage takes new data when empty or when its successor loads
    always_comb begin
        w_ld[S-1] = !r_vld[S-1] || i_out_ready;
        for (int k = S - 2; k >= 0; k--) begin
            w_ld[k] = !r_vld[k] || w_ld[k+1];
        end
    end

    assign w_vld_in = {r_vld[S-2:0], i_in_valid};

    always_comb begin
        for (int k = 0; k < S; k++) begin
            n_vld[k] = w_ld[k] ? w_vld_in[k] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = w_ld[0];
    assign o_out_valid = r_vld[S-1];

    // Start vector: x = 1.0, y = 0, z = angle
    assign w_x[0] = X_INIT;
    assign w_y[0] = '0;
    assign w_z[0] = ZW'(i_angle);

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_rot
        csc_rot_stage #(
            .XW        (XW),
            .ZW        (ZW),
            .IDX       (g),
            .FRAC_BITS (FRAC_BITS)
        ) u_stage (
            .i_clk (i_clk),
            .i_ld  (w_ld[g]),
            .i_x   (w_x[g]),
            .i_y   (w_y[g]),
            .i_z   (w_z[g]),
            .o_x   (w_x[g+1]),
            .o_y   (w_y[g+1]),
            .o_z   (w_z[g+1])
        );
    end

    // Apply the fixed gain
    always_ff @(posedge i_clk) begin
        if (w_ld[ITERATIONS]) begin
            r_prod_s <= PW'(w_y[ITERATIONS]) * PW'(GAIN_Q30);
            r_prod_c <= PW'(w_x[ITERATIONS]) * PW'(GAIN_Q30);
        end
    end

    // Drop the Q30 gain fraction (floor), then clamp to 16 bits
    assign w_sh_s = r_prod_s >>> GAIN_SHIFT;
    assign w_sh_c = r_prod_c >>> GAIN_SHIFT;

    always_comb begin
        if (w_sh_s > SAT_HI) begin
            n_sine = OUT_W'(SAT_HI);
        end else if (w_sh_s < SAT_LO) begin
            n_sine = OUT_W'(SAT_LO);
        end else begin
            n_sine = OUT_W'(w_sh_s);
        end
        if (w_sh_c > SAT_HI) begin
            n_cosine = OUT_W'(SAT_HI);
        end else if (w_sh_c < SAT_LO) begin
            n_cosine = OUT_W'(SAT_LO);
        end else begin
            n_cosine = OUT_W'(w_sh_c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[S-1]) begin
            r_sine   <= n_sine;
            r_cosine <= n_cosine;
        end
    end

    assign o_sine   = r_sine;
    assign o_cosine = r_cosine;

`ifndef SYNTHESIS
    // Back-pressure reaches the input only when every stage is occupied
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_vld))
        else $error("input stalled while the pipeline has a bubble");

    // An accepted transaction lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted transaction lost at the first stage");

    // A free output side never blocks the input
    a_free_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input blocked while the output side is free");
`endif

endmodule

// ===== rtl/core/csc_rot_stage.sv =====
module csc_rot_stage
    import csc_pkg::*;
#(
    parameter int XW        = 17,
    parameter int ZW        = 17,
    parameter int IDX       = 0,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_ld,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [ZW-1:0] o_z
);

    localparam logic signed [ZW-1:0] ATAN = ZW'(csc_atan(IDX, FRAC_BITS));

    logic signed [XW-1:0] w_xs;
    logic signed [XW-1:0] w_ys;
    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    logic signed [ZW-1:0] n_z;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;

    assign w_xs = i_x >>> IDX;
    assign w_ys = i_y >>> IDX;

    // rotate toward zero remaining angle; zero counts as non-negative
    always_comb begin
        if (i_z[ZW-1]) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// ===== tb/tb_cordic_sin_cos.sv =====
`timescale 1ns / 100ps

module tb_cordic_sin_cos
    import csc_pkg::*;
;

    // Build the block at its default configuration and mirror it here.
    localparam int ROT_STEPS  = ITERATIONS_DEF;
    localparam int FRAC       = FRAC_BITS_DEF;
    localparam int LATENCY    = ROT_STEPS + 2;
    localparam int RAND_COUNT = 1700;
    localparam longint CYCLE_LIMIT = 1000000;

    // Angle near the edge of the convergence range (about 1.74 rad in Q2.14).
    localparam int CONV_EDGE  = 28508;
    // atan(1) after rounding to 14 fraction bits; lands the remaining angle on zero.
    localparam int ATAN0_Q14  = 12868;
    // atan(1) - atan(0.5): remaining angle reaches zero after the second rotation.
    localparam int ZERO_AT_2  = 5272;
    localparam int HALF_PI    = 25736;

    typedef struct packed {
        logic signed [OUT_W-1:0] sine;
        logic signed [OUT_W-1:0] cosine;
    } t_sincos;

    typedef struct {
        logic signed [ANGLE_W-1:0] angle;
        bit                        typed;   // expected value given by hand
        logic signed [OUT_W-1:0]   sine;
        logic signed [OUT_W-1:0]   cosine;
    } t_angle_row;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic signed [ANGLE_W-1:0] i_angle     = '0;
    logic                      i_out_ready = 1'b0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic signed [OUT_W-1:0]   o_sine;
    logic signed [OUT_W-1:0]   o_cosine;

    t_sincos sincos_q[$];          // results still owed by the block, oldest first
    int      mismatches   = 0;
    int      results_seen = 0;
    int      sent_directed = 0;
    int      sent_random  = 0;
    longint  cycles       = 0;
    bit      tail         = 1'b0;  // stimulus done: stop stalling the output
    int      send_mode    = 0;     // 0 = back to back, 1 = light gaps, 2 = heavy gaps
    int      recv_mode    = 0;
    int      stall_left   = 0;

    // Zero-angle row: worked through by hand, seven rotations then the gain.
    t_angle_row directed_rows[] = '{
        '{16'sd0,                1'b1, -16'sd13, 16'sd16384},
        '{16'sh7FFF,             1'b0, '0, '0},
        '{16'sh8000,             1'b0, '0, '0},
        '{16'sd1,                1'b0, '0, '0},
        '{-16'sd1,               1'b0, '0, '0},
        '{16'sd16384,            1'b0, '0, '0},
        '{-16'sd16384,           1'b0, '0, '0},
        '{16'(HALF_PI),          1'b0, '0, '0},
        '{-16'(HALF_PI),         1'b0, '0, '0},
        '{16'(CONV_EDGE),        1'b0, '0, '0},
        '{-16'(CONV_EDGE),       1'b0, '0, '0},
        '{16'(ATAN0_Q14),        1'b0, '0, '0},
        '{-16'(ATAN0_Q14),       1'b0, '0, '0},
        '{16'(ZERO_AT_2),        1'b0, '0, '0},
        '{-16'(ZERO_AT_2),       1'b0, '0, '0},
        '{16'sh5555,             1'b0, '0, '0},
        '{16'shAAAA,             1'b0, '0, '0},
        '{16'sd8192,             1'b0, '0, '0},
        '{-16'sd8192,            1'b0, '0, '0},
        '{16'sd32000,            1'b0, '0, '0},
        '{-16'sd32000,           1'b0, '0, '0}
    };

    cordic_sin_cos #(
        .ITERATIONS(ROT_STEPS),
        .FRAC_BITS (FRAC)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_angle    (i_angle),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_sine     (o_sine),
        .o_cosine   (o_cosine)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a hung handshake must not let the run go on forever.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Run timed out after %0d cycles, %0d results owed", cycles,
                     sincos_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Saturate a gain-scaled value to the signed output range.
    function automatic logic signed [OUT_W-1:0] scale_by_gain(input longint v);
        longint p;
        p = (v * longint'(GAIN_Q30)) >>> GAIN_SHIFT;
        if (p > OUT_MAX)
            p = OUT_MAX;
        if (p < OUT_MIN)
            p = OUT_MIN;
        return p[OUT_W-1:0];
    endfunction

    // Rotation-mode CORDIC: start at (1, 0), steer each micro-rotation by the sign
    // of the remaining angle, shifts floor, atan constants rounded half up.
    function automatic t_sincos cordic_sincos(input logic signed [ANGLE_W-1:0] angle);
        longint  x;
        longint  y;
        longint  z;
        longint  xs;
        longint  ys;
        longint  step;
        int      drop;
        int      n;
        int      i;
        t_sincos r;
        x    = longint'(1) << FRAC;
        y    = 0;
        z    = angle;
        drop = (FRAC >= 30) ? 0 : 30 - FRAC;
        n    = (ROT_STEPS > TABLE_LEN) ? TABLE_LEN : ROT_STEPS;
        for (i = 0; i < n; i++) begin
            xs   = x >>> i;
            ys   = y >>> i;
            step = ATAN_Q30[i];
            if (drop != 0)
                step = (step + (longint'(1) << (drop - 1))) >>> drop;
            // A zero remaining angle rotates the positive way.
            if (z < 0) begin
                x = x + ys;
                y = y - xs;
                z = z + step;
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - step;
            end
        end
        r.sine   = scale_by_gain(y);
        r.cosine = scale_by_gain(x);
        return r;
    endfunction

    // Angle mix: mostly inside the convergence range, some near zero and near the
    // first atan constant or atan(1) - atan(0.5), the rest anywhere in the 16-bit field.
    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        int pick;
        int base;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 16'($urandom_range(0, 2 * CONV_EDGE) - CONV_EDGE);
        if (pick < 68)
            return 16'($urandom_range(0, 128) - 64);
        if (pick < 80) begin
            base = ($urandom_range(0, 1) != 0) ? ATAN0_Q14 : ZERO_AT_2;
            base = base + $urandom_range(0, 4) - 2;
            return ($urandom_range(0, 1) != 0) ? 16'(base) : 16'(-base);
        end
        return 16'($urandom);
    endfunction

    // Mode 0 never gaps; otherwise mostly short gaps, now and then a long one.
    function automatic int pick_gap(input int mode);
        if (mode == 0)
            return 0;
        if ($urandom_range(0, 99) >= ((mode == 1) ? 25 : 60))
            return 0;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Offer one angle after an optional gap; return at the edge that takes it.
    // Called at a rising edge, returns at a rising edge.
    task automatic send_angle(input logic signed [ANGLE_W-1:0] angle, input t_sincos exp_res);
        int gap;
        int k;
        gap = pick_gap(send_mode);
        for (k = 0; k < gap; k++) begin
            // Idle: drop valid and scramble the angle so a stale value is not trusted.
            i_in_valid <= 1'b0;
            i_angle    <= 16'($urandom);
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_angle    <= angle;
        do
            @(posedge i_clk);
        while (o_in_ready !== 1'b1);
        sincos_q.push_back(exp_res);
    endtask

    // Hold off the input until every owed result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (sincos_q.size() != 0);
    endtask

    // Output side: check each transaction against the oldest owed result,
    // then choose ready for the next cycle.
    always @(posedge i_clk) begin
        t_sincos exp_res;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            results_seen++;
            if (sincos_q.size() == 0) begin
                $error("unexpected result: sine %0d cosine %0d", o_sine, o_cosine);
                mismatches++;
            end else begin
                exp_res = sincos_q.pop_front();
                if (o_sine !== exp_res.sine) begin
                    $error("sine mismatch: expected %0d, actual %0d", exp_res.sine, o_sine);
                    mismatches++;
                end
                if (o_cosine !== exp_res.cosine) begin
                    $error("cosine mismatch: expected %0d, actual %0d",
                           exp_res.cosine, o_cosine);
                    mismatches++;
                end
            end
        end
        // Switch the stall profile at regular points of the cycle counter, so some
        // stretches run with ready held high throughout.
        if (cycles % 300 == 0)
            recv_mode = $urandom_range(0, 2);
        if (tail || recv_mode == 0) begin
            stall_left  = 0;
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            stall_left  = pick_gap(recv_mode);
            i_out_ready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    initial begin
        int      k;
        t_sincos exp_res;
        logic signed [ANGLE_W-1:0] angle;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: back to back first, hand-typed values where given.
        send_mode = 0;
        foreach (directed_rows[r]) begin
            if (directed_rows[r].typed) begin
                exp_res.sine   = directed_rows[r].sine;
                exp_res.cosine = directed_rows[r].cosine;
            end else begin
                exp_res = cordic_sincos(directed_rows[r].angle);
            end
            send_angle(directed_rows[r].angle, exp_res);
            sent_directed++;
        end
        drain_results();

        // Random angles, gap profile changing every hundred transactions and
        // a full drain every few hundred.
        for (k = 0; k < RAND_COUNT; k++) begin
            if (k % 100 == 0)
                send_mode = $urandom_range(0, 2);
            if (k % 450 == 449)
                drain_results();
            angle = pick_angle();
            send_angle(angle, cordic_sincos(angle));
            sent_random++;
        end

        // Stop stalling, collect the rest, then watch a little longer for extras.
        tail = 1'b1;
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (sincos_q.size() != 0);
        repeat (LATENCY + 20) @(posedge i_clk);

        $display("Checked %0d directed and %0d random angles; %0d results compared, %0d errors",
                 sent_directed, sent_random, results_seen, mismatches);
        if (mismatches == 0 && sincos_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
